>>> rtl/core/assert_macros.svh
// Assertion macros shared by the leveler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define AGC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define AGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/alevl_pkg.sv
// ----------------------------------------------------------------------------
// alevl_pkg
// Types, constants and helpers for the receive step AGC peak leveler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alevl_pkg;

  localparam logic signed [7:0] GAIN_MIN      = -8'sd24;
  localparam logic [11:0]       RAIL_PEAK     = 12'd2040;
  localparam logic [6:0]        STEP_BASE_DB  = 7'd6;
  localparam logic [6:0]        STEP_RAIL_DB  = 7'd12;
  localparam logic [15:0]       HOLD_SAT      = 16'hFFFF;
  localparam int unsigned       CFG_AW        = 5;
  localparam int unsigned       CFG_DW        = 32;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_WIN_END = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_ATTACK = 2'd1,
    EVT_DECAY  = 2'd2,
    EVT_BLANK  = 2'd3
  } evt_t;

  typedef enum logic [2:0] {
    REG_ATTACK_THR  = 3'd0,
    REG_DECAY_THR   = 3'd1,
    REG_HOLD_TIME   = 3'd2,
    REG_UP_STEP     = 3'd3,
    REG_STEP_SETTLE = 3'd4,
    REG_RST_SETTLE  = 3'd5,
    REG_GAIN_MAX    = 3'd6,
    REG_LOOP_EN     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_APPLY
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [23:0] packed_group;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        window_peak;
    logic signed [7:0]  gain_db;
    evt_t               event_res;
    logic [6:0]         step_db;
  } out_item_t;

  typedef struct packed {
    logic [11:0]       attack_threshold;
    logic [11:0]       decay_threshold;
    logic [15:0]       hold_time_ms;
    logic [5:0]        up_step_db;
    logic [15:0]       step_settle_ms;
    logic [15:0]       restart_settle_ms;
    logic signed [7:0] gain_max;
    logic              loop_enable;
  } cfg_t;

  typedef struct packed {
    logic sample;
    logic tick;
    logic restart;
    logic win_start;
    logic scale_step;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scale_more;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [11:0] mag12(input logic [11:0] v);
    return v[11] ? (12'h000 - v) : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/alevl_regs.sv
// ----------------------------------------------------------------------------
// alevl_regs
// APB-style configuration register file for the peak leveler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alevl_regs
  import alevl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output      logic [CFG_DW-1:0] cfg_prdata,
  output      logic              cfg_pready,
  output      cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ATTACK_THR:  cfg_nxt.attack_threshold  = cfg_pwdata[11:0];
        REG_DECAY_THR:   cfg_nxt.decay_threshold   = cfg_pwdata[11:0];
        REG_HOLD_TIME:   cfg_nxt.hold_time_ms      = cfg_pwdata[15:0];
        REG_UP_STEP:     cfg_nxt.up_step_db        = cfg_pwdata[5:0];
        REG_STEP_SETTLE: cfg_nxt.step_settle_ms    = cfg_pwdata[15:0];
        REG_RST_SETTLE:  cfg_nxt.restart_settle_ms = cfg_pwdata[15:0];
        REG_GAIN_MAX:    cfg_nxt.gain_max          = cfg_pwdata[7:0];
        REG_LOOP_EN:     cfg_nxt.loop_enable       = cfg_pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ATTACK_THR:  cfg_prdata = {20'd0, cfg_r.attack_threshold};
      REG_DECAY_THR:   cfg_prdata = {20'd0, cfg_r.decay_threshold};
      REG_HOLD_TIME:   cfg_prdata = {16'd0, cfg_r.hold_time_ms};
      REG_UP_STEP:     cfg_prdata = {26'd0, cfg_r.up_step_db};
      REG_STEP_SETTLE: cfg_prdata = {16'd0, cfg_r.step_settle_ms};
      REG_RST_SETTLE:  cfg_prdata = {16'd0, cfg_r.restart_settle_ms};
      REG_GAIN_MAX:    cfg_prdata = {24'd0, cfg_r.gain_max};
      REG_LOOP_EN:     cfg_prdata = {31'd0, cfg_r.loop_enable};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_threshold  <= 12'd1450;
      cfg_r.decay_threshold   <= 12'd260;
      cfg_r.hold_time_ms      <= 16'd500;
      cfg_r.up_step_db        <= 6'd2;
      cfg_r.step_settle_ms    <= 16'd50;
      cfg_r.restart_settle_ms <= 16'd300;
      cfg_r.gain_max          <= 8'sd63;
      cfg_r.loop_enable       <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/alevl_ctrl.sv
// ----------------------------------------------------------------------------
// alevl_ctrl
// Controller: decodes transactions and sequences the window-end decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alevl_ctrl
  import alevl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire action_t in_action,
  output      logic    in_ready,
  input  wire dp_stat_t stat,
  output      ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && (in_action == ACT_WIN_END)) state_nxt = ST_SCALE;
      ST_SCALE: if (!stat.scale_more) state_nxt = ST_APPLY;
      ST_APPLY: if (!stat.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.sample    = in_valid && (in_action == ACT_SAMPLE);
        cmd.tick      = in_valid && (in_action == ACT_TICK);
        cmd.restart   = in_valid && (in_action == ACT_RESTART);
        cmd.win_start = in_valid && (in_action == ACT_WIN_END);
      end
      ST_SCALE: cmd.scale_step = stat.scale_more;
      ST_APPLY: cmd.apply      = !stat.out_busy;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `AGC_ASSERT(a_busy_stalls_input, clk, rst_n, (state_r != ST_IDLE) |-> !in_ready, "input taken while busy")
  `AGC_ASSERT(a_win_enters_scale, clk, rst_n, cmd.win_start |=> (state_r == ST_SCALE), "window end not sequenced")
  `AGC_ASSERT(a_apply_needs_slot, clk, rst_n, cmd.apply |-> !stat.out_busy, "result overwrites pending result")
  `AGC_ASSERT(a_one_cmd, clk, rst_n, $onehot0(cmd), "more than one command issued")

endmodule

`default_nettype wire

>>> rtl/core/alevl_dp.sv
// ----------------------------------------------------------------------------
// alevl_dp
// Datapath: peak tracking, timers, gain decision and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alevl_dp
  import alevl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic [23:0] group,
  input  wire ctrl_cmd_t   cmd,
  output      dp_stat_t    stat,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      out_item_t   out_data
);

  logic [11:0]       peak_hold_r, peak_hold_nxt;
  logic signed [7:0] gain_r, gain_nxt;
  logic              armed_r, armed_nxt;
  logic [15:0]       hold_cnt_r, hold_cnt_nxt;
  logic [15:0]       blank_cnt_r, blank_cnt_nxt;
  logic [11:0]       win_peak_r, win_peak_nxt;
  logic [12:0]       thr_sh_r, thr_sh_nxt;
  logic [6:0]        down_r, down_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [11:0]       mag_i, mag_q, thr_eff;
  logic [6:0]        down_sel;
  logic signed [9:0] gain_ext, gmax_ext, gmin_ext, att_ng, dec_ng, new_g, diff;

  assign mag_i    = mag12(group[23:12]);
  assign mag_q    = mag12(group[11:0]);
  assign thr_eff  = (cfg.attack_threshold == 12'd0) ? 12'd1 : cfg.attack_threshold;
  assign gain_ext = 10'(gain_r);
  assign gmax_ext = 10'(cfg.gain_max);
  assign gmin_ext = 10'(GAIN_MIN);
  assign down_sel = (win_peak_r >= RAIL_PEAK) ? STEP_RAIL_DB : down_r;
  assign att_ng   = (gain_ext - signed'({3'd0, down_sel}) < gmin_ext) ? gmin_ext
                    : gain_ext - signed'({3'd0, down_sel});
  assign dec_ng   = (gain_ext + signed'({4'd0, cfg.up_step_db}) > gmax_ext) ? gmax_ext
                    : gain_ext + signed'({4'd0, cfg.up_step_db});

  assign stat.scale_more = (win_peak_r < RAIL_PEAK) && ({1'b0, win_peak_r} >= thr_sh_r);
  assign stat.out_busy   = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  always_comb begin
    peak_hold_nxt = peak_hold_r;
    gain_nxt      = gain_r;
    armed_nxt     = armed_r;
    hold_cnt_nxt  = hold_cnt_r;
    blank_cnt_nxt = blank_cnt_r;
    win_peak_nxt  = win_peak_r;
    thr_sh_nxt    = thr_sh_r;
    down_nxt      = down_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    new_g         = gain_ext;
    diff          = '0;

    if (cmd.sample) begin
      if (mag_i > peak_hold_nxt) peak_hold_nxt = mag_i;
      if (mag_q > peak_hold_nxt) peak_hold_nxt = mag_q;
    end
    if (cmd.tick) begin
      if (blank_cnt_r != 16'd0) blank_cnt_nxt = blank_cnt_r - 16'd1;
      if (armed_r && (hold_cnt_r != HOLD_SAT)) hold_cnt_nxt = hold_cnt_r + 16'd1;
    end
    if (cmd.restart) begin
      blank_cnt_nxt = cfg.restart_settle_ms;
      armed_nxt     = 1'b0;
      hold_cnt_nxt  = 16'd0;
      peak_hold_nxt = 12'd0;
    end
    if (cmd.win_start) begin
      win_peak_nxt  = peak_hold_r;
      peak_hold_nxt = 12'd0;
      thr_sh_nxt    = {thr_eff, 1'b0};
      down_nxt      = STEP_BASE_DB;
    end
    if (cmd.scale_step) begin
      thr_sh_nxt = {thr_sh_r[11:0], 1'b0};
      down_nxt   = down_r + STEP_BASE_DB;
    end
    if (cmd.apply) begin
      out_data_nxt.event_res = EVT_NONE;
      priority if ((blank_cnt_r != 16'd0) || (win_peak_r == 12'd0)) begin
        out_data_nxt.event_res = EVT_BLANK;
      end else if (!cfg.loop_enable) begin
        armed_nxt    = 1'b0;
        hold_cnt_nxt = 16'd0;
      end else if (win_peak_r >= cfg.attack_threshold) begin
        new_g                  = att_ng;
        diff                   = gain_ext - att_ng;
        out_data_nxt.event_res = EVT_ATTACK;
        blank_cnt_nxt          = cfg.step_settle_ms;
        armed_nxt              = 1'b0;
        hold_cnt_nxt           = 16'd0;
      end else if (win_peak_r < cfg.decay_threshold) begin
        if (!armed_r) begin
          armed_nxt    = 1'b1;
          hold_cnt_nxt = 16'd0;
        end else if (hold_cnt_r >= cfg.hold_time_ms) begin
          if (gain_r < cfg.gain_max) begin
            new_g                  = dec_ng;
            diff                   = dec_ng - gain_ext;
            out_data_nxt.event_res = EVT_DECAY;
            blank_cnt_nxt          = cfg.step_settle_ms;
          end
          armed_nxt    = 1'b0;
          hold_cnt_nxt = 16'd0;
        end
      end else begin
        armed_nxt    = 1'b0;
        hold_cnt_nxt = 16'd0;
      end
      gain_nxt                 = new_g[7:0];
      out_data_nxt.window_peak = win_peak_r;
      out_data_nxt.gain_db     = new_g[7:0];
      out_data_nxt.step_db     = diff[6:0];
      out_valid_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_hold_r <= 12'd0;
      gain_r      <= 8'sd0;
      armed_r     <= 1'b0;
      hold_cnt_r  <= 16'd0;
      blank_cnt_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      peak_hold_r <= peak_hold_nxt;
      gain_r      <= gain_nxt;
      armed_r     <= armed_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      blank_cnt_r <= blank_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_peak_r <= win_peak_nxt;
    thr_sh_r   <= thr_sh_nxt;
    down_r     <= down_nxt;
    out_data_r <= out_data_nxt;
  end

  `AGC_ASSERT(a_gain_floor, clk, rst_n, gain_r >= GAIN_MIN, "gain below floor")
  `AGC_ASSERT(a_hold_clear_unarmed, clk, rst_n, !armed_r |-> (hold_cnt_r == 16'd0), "hold runs unarmed")

endmodule

`default_nettype wire

>>> rtl/core/rx_step_agc_peak_leveler.sv
// Sequencing: samples, ticks and restarts update the registered state when accepted; a window
// end passes through the scale state (one threshold doubling per pass), then the apply state,
// which loads its result register once the output register is free to take it.
// Throughput: 1 item per cycle except after a window end, which holds the input until
// its result enters the output register, after the doubling loop and any output back-pressure.
// Reset: rst_n synchronous, active low; registers load defaults, gain 0 dB, timers clear.
// ----------------------------------------------------------------------------
// rx_step_agc_peak_leveler
// Receive step AGC with window peak detection, hold and blanking timers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rx_step_agc_peak_leveler
  import alevl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire in_item_t          in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      out_item_t         out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output      logic [CFG_DW-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  alevl_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  alevl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  alevl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .group     (in_data.packed_group),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the receive step AGC peak leveler: drives sample
// groups, ticks, window ends and restarts under bursty traffic and random
// output back-pressure, and checks every window decision against a
// cycle-free model of peak tracking, attack, hold/decay and blanking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import alevl_pkg::*;

  localparam int QUIET_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int HOLDOFF_AFTER  = 60;
  localparam int PHASE_ITEMS    = 65;

  typedef enum {
    CFG_DIRECTED,
    CFG_RANDOM,
    CFG_LOW,
    CFG_HIGH,
    CFG_LOOP_OFF
  } cfg_kind_t;

  class agc_window_checker;
    bit [11:0]        atk_thr;
    bit [11:0]        dec_thr;
    bit [15:0]        hold_ms;
    bit [5:0]         up_db;
    bit [15:0]        step_settle;
    bit [15:0]        restart_settle;
    bit signed [7:0]  gain_cap;
    bit               loop_on;

    bit [11:0]        peak;
    bit signed [7:0]  gain;
    bit               armed;
    bit [15:0]        hold_cnt;
    bit [15:0]        blank_cnt;

    out_item_t        expected_windows[$];
    int               n_checked;
    int               n_bad;

    function new();
      atk_thr        = 12'd1450;
      dec_thr        = 12'd260;
      hold_ms        = 16'd500;
      up_db          = 6'd2;
      step_settle    = 16'd50;
      restart_settle = 16'd300;
      gain_cap       = 8'sd63;
      loop_on        = 1'b1;
      peak           = '0;
      gain           = '0;
      armed          = 1'b0;
      hold_cnt       = '0;
      blank_cnt      = '0;
      n_checked      = 0;
      n_bad          = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_ATTACK_THR:  atk_thr        = v[11:0];
        REG_DECAY_THR:   dec_thr        = v[11:0];
        REG_HOLD_TIME:   hold_ms        = v[15:0];
        REG_UP_STEP:     up_db          = v[5:0];
        REG_STEP_SETTLE: step_settle    = v[15:0];
        REG_RST_SETTLE:  restart_settle = v[15:0];
        REG_GAIN_MAX:    gain_cap       = v[7:0];
        REG_LOOP_EN:     loop_on        = v[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction

    function bit [11:0] magnitude(bit [11:0] v);
      return v[11] ? (~v + 12'd1) : v;
    endfunction

    function void drop_hold();
      armed    = 1'b0;
      hold_cnt = '0;
    endfunction

    function void take_item(in_item_t it);
      bit [11:0] mi;
      bit [11:0] mq;
      bit [11:0] p;
      evt_t      evt;
      int        g;
      int        ng;
      int        cap;
      int        down;
      int        ratio;
      int        step;
      out_item_t r;
      case (it.action)
        ACT_SAMPLE: begin
          mi = magnitude(it.packed_group[23:12]);
          mq = magnitude(it.packed_group[11:0]);
          if (mi > peak) peak = mi;
          if (mq > peak) peak = mq;
        end
        ACT_TICK: begin
          if (blank_cnt != 0) blank_cnt--;
          if (armed && hold_cnt != 16'hFFFF) hold_cnt++;
        end
        ACT_RESTART: begin
          blank_cnt = restart_settle;
          drop_hold();
          peak = '0;
        end
        default: begin
          p    = peak;
          evt  = EVT_NONE;
          step = 0;
          g    = gain;
          cap  = gain_cap;
          if (blank_cnt != 0 || p == 0) begin
            evt = EVT_BLANK;
          end else if (!loop_on) begin
            drop_hold();
          end else if (p >= atk_thr) begin
            down = 6;
            if (p >= RAIL_PEAK) begin
              down = 12;
            end else begin
              ratio = p;
              ratio = ratio / ((atk_thr == 0) ? 1 : int'(atk_thr));
              while (ratio > 1) begin
                down += 6;
                ratio = ratio >> 1;
              end
            end
            ng = g - down;
            if (ng < int'(GAIN_MIN)) ng = GAIN_MIN;
            if (ng > g) ng = g;
            step      = g - ng;
            gain      = 8'(ng);
            evt       = EVT_ATTACK;
            blank_cnt = step_settle;
            drop_hold();
          end else if (p < dec_thr) begin
            if (!armed) begin
              armed    = 1'b1;
              hold_cnt = '0;
            end else if (hold_cnt >= hold_ms) begin
              if (g < cap) begin
                ng = g + int'(up_db);
                if (ng > cap) ng = cap;
                step      = ng - g;
                gain      = 8'(ng);
                evt       = EVT_DECAY;
                blank_cnt = step_settle;
              end
              drop_hold();
            end
          end else begin
            drop_hold();
          end
          peak          = '0;
          r.window_peak = p;
          r.gain_db     = gain;
          r.event_res   = evt;
          r.step_db     = 7'(step);
          expected_windows.push_back(r);
        end
      endcase
    endfunction

    function void check_window(out_item_t got);
      out_item_t want;
      n_checked++;
      if (expected_windows.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("ERROR: unexpected window result: peak %0d gain %0d event %0d step %0d",
                   got.window_peak, got.gain_db, got.event_res, got.step_db);
        return;
      end
      want = expected_windows.pop_front();
      if (got.window_peak !== want.window_peak || got.gain_db !== want.gain_db ||
          got.event_res !== want.event_res || got.step_db !== want.step_db) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"ERROR: window %0d mismatch: expected peak %0d gain %0d event %0d ",
                    "step %0d, got peak %0d gain %0d event %0d step %0d"},
                   n_checked, want.window_peak, want.gain_db, want.event_res, want.step_db,
                   got.window_peak, got.gain_db, got.event_res, got.step_db);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  agc_window_checker chk = new();
  int                quiet_cycles;
  int                items_sent;
  int                burst_left;
  bit                held_off;

  rx_step_agc_peak_leveler dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_ready) chk.check_window(out_data);
      if (in_valid && in_ready === 1'b1) chk.take_item(in_data);
    end
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("ERROR: watchdog, no transaction for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int mode;
    int mode_left;
    int pat;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    pat       = 0;
    forever begin
      @(negedge clk);
      if (!held_off && chk.n_checked >= HOLDOFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      pat++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(3) != 0);
        default: out_ready <= (pat % 4 == 0);
      endcase
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_act(action_t a, bit [23:0] g);
    in_item_t it;
    it.action       = a;
    it.packed_group = g;
    send_item(it);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, bit [31:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    chk.write_reg(idx, v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(cfg_kind_t kind);
    bit [31:0] v [8];
    v[0] = ($urandom_range(4) == 0) ? $urandom_range(1, 64) : $urandom_range(300, 2047);
    v[1] = $urandom_range(0, v[0]);
    v[2] = $urandom_range(0, 3);
    v[3] = $urandom_range(0, 63);
    v[4] = $urandom_range(0, 2);
    v[5] = $urandom_range(0, 3);
    v[6] = ($urandom_range(0, 40) - 24) & 32'hFF;
    v[7] = 1;
    case (kind)
      CFG_DIRECTED: v = '{100, 40, 1, 5, 0, 2, 3, 1};
      CFG_LOW:      v = '{0, 0, 0, 0, 0, 0, 32'h80, 1};
      CFG_HIGH:     v = '{32'hFFF, 32'hFFF, 32'hFFFF, 63, 32'hFFFF, 32'hFFFF, 127, 1};
      CFG_LOOP_OFF: v[7] = 0;
      default: ;
    endcase
    for (int i = 0; i < 8; i++) write_cfg(reg_idx_t'(i), v[i]);
  endtask

  function automatic bit [11:0] signed_of(int unsigned m);
    if (m >= 2048) return 12'h800;
    if ($urandom_range(1)) return 12'(0 - m);
    return 12'(m);
  endfunction

  function automatic int unsigned pick_peak();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r < 9) begin
      hi = (chk.dec_thr > 1) ? chk.dec_thr - 1 : 1;
      if (hi > 2048) hi = 2048;
      return $urandom_range(1, hi);
    end
    if (r < 13) return $urandom_range(1, 2048);
    if (r < 17) begin
      lo = (chk.atk_thr == 0) ? 1 : chk.atk_thr;
      if (lo > 2048) lo = 2048;
      return $urandom_range(lo, 2048);
    end
    return $urandom_range(2038, 2048);
  endfunction

  task automatic run_window();
    int unsigned target;
    int unsigned other;
    in_item_t    it;
    target = pick_peak();
    if (target != 0) begin
      repeat ($urandom_range(1, 4)) begin
        it.action = ACT_SAMPLE;
        other     = $urandom_range(0, target);
        if ($urandom_range(4) == 0)
          it.packed_group = 24'($urandom);
        else if ($urandom_range(1))
          it.packed_group = {signed_of(target), signed_of(other)};
        else
          it.packed_group = {signed_of(other), signed_of(target)};
        send_item(it);
      end
    end
    repeat ($urandom_range(0, 4)) send_act(ACT_TICK, 24'($urandom));
    if ($urandom_range(19) == 0) send_act(ACT_RESTART, 24'($urandom));
    if ($urandom_range(19) == 0) send_act(action_t'($urandom_range(3)), 24'($urandom));
    send_act(ACT_WIN_END, 24'($urandom));
  endtask

  task automatic run_phase(cfg_kind_t kind);
    int start;
    configure(kind);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) run_window();
    settle();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    items_sent  = 0;
    burst_left  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_SAMPLE,  24'h5DC000);
    send_act(ACT_WIN_END, 24'hFFFFFF);
    send_act(ACT_WIN_END, 24'h000000);
    settle();

    configure(CFG_DIRECTED);
    send_act(ACT_SAMPLE,  24'h800800);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_SAMPLE,  24'h7FF001);
    send_act(ACT_WIN_END, 24'hFFFFFF);
    send_act(ACT_SAMPLE,  24'hFFFFFF);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_TICK,    24'h000000);
    send_act(ACT_TICK,    24'hFFFFFF);
    send_act(ACT_SAMPLE,  24'h00001F);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_SAMPLE,  24'h000FFF);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_SAMPLE,  24'h190000);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_RESTART, 24'hFFFFFF);
    send_act(ACT_SAMPLE,  24'h064000);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_TICK,    24'h000000);
    send_act(ACT_TICK,    24'h000000);
    send_act(ACT_SAMPLE,  24'h000800);
    send_act(ACT_WIN_END, 24'h000000);
    send_act(ACT_SAMPLE,  24'h03C000);
    send_act(ACT_WIN_END, 24'h000000);
    settle();

    run_phase(CFG_RANDOM);
    run_phase(CFG_LOW);
    run_phase(CFG_LOOP_OFF);
    run_phase(CFG_HIGH);
    run_phase(CFG_RANDOM);
    run_phase(CFG_RANDOM);

    if (chk.n_bad == 0 && chk.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> rx_step_agc_peak_leveler.f
+incdir+rtl/core
rtl/core/alevl_pkg.sv
rtl/core/alevl_regs.sv
rtl/core/alevl_ctrl.sv
rtl/core/alevl_dp.sv
rtl/core/rx_step_agc_peak_leveler.sv
tb/sv/tb_top.sv
